/* src/psp_pkg.sv */
// Shared types, codes and constants of the PSG register dump stream parser.
// No dependencies; used by psp_parse, psp_outq and psg_stream_parser_top.
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    // Header layout
    localparam int unsigned HdrLen   = 16;
    localparam int unsigned VerPos   = 4;
    localparam int unsigned SigLen   = 4;

    // Marker bytes
    localparam logic [7:0] MARK_FORMAT = 8'h1A;
    localparam logic [7:0] MARK_PAUSE  = 8'hFF;
    localparam logic [7:0] MARK_SKIP   = 8'hFE;
    localparam logic [7:0] MARK_END    = 8'hFD;
    localparam logic [7:0] REG_LIMIT   = 8'd15;

    // Parse phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_REG   = 2'd2;
    localparam logic [1:0] PH_ENDED = 2'd3;

    // Result kinds
    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_PAUSE = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;
    localparam logic [1:0] K_ERROR = 2'd3;

    // Configuration register indexes
    localparam logic CFG_COUNT_ONLY = 1'b0;
    localparam logic CFG_CHIP       = 1'b1;

    // Result queue depth
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    typedef struct packed {
        logic [1:0]  kind;
        logic        chip;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic [9:0]  pause_count;
        logic [31:0] tick_total;
        logic        last_result;
    } t_result;

    // Up to two results per beat, slot 0 first
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Signature bytes 'P', 'S', 'G', 0x1A
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] v;
        case (pos)
            2'd0:    v = 8'h50;
            2'd1:    v = 8'h53;
            2'd2:    v = 8'h47;
            default: v = MARK_FORMAT;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/psp_parse.sv */
// Parser state and per-beat decode: header check, body codes, tick total.
// Depends on psp_pkg; feeds up to two results per beat into psp_outq.
`timescale 1ns / 1ps
`default_nettype none

module psp_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_first,
    input  wire logic          i_last,
    input  wire logic          i_count_only,
    input  wire logic          i_chip,
    output psp_pkg::t_push     o_push
);
    import psp_pkg::*;

    logic [4:0]  r_hdr_pos,  n_hdr_pos;
    logic [1:0]  r_phase,    n_phase;
    logic [3:0]  r_latch,    n_latch;
    logic [31:0] r_ticks,    n_ticks;
    logic        r_failed,   n_failed;
    logic        r_body_ver, n_body_ver;

    // state seen by this beat (first byte restarts the parser)
    logic [4:0]  e_hdr_pos;
    logic [1:0]  e_phase;
    logic [3:0]  e_latch;
    logic [31:0] e_ticks;
    logic        e_failed, e_body_ver;

    logic        active, sig_err, is_body, ver_n;
    logic        body_v, term_v;
    t_result     body_r, term_r, err_r;
    logic [9:0]  add_ticks;
    logic [1:0]  phase_b;
    logic [32:0] tick_sum;
    logic [9:0]  skip_cnt;

    always_comb begin
        e_hdr_pos  = i_first ? '0 : r_hdr_pos;
        e_phase    = i_first ? PH_IDLE : r_phase;
        e_latch    = i_first ? '0 : r_latch;
        e_ticks    = i_first ? '0 : r_ticks;
        e_failed   = i_first ? 1'b0 : r_failed;
        e_body_ver = i_first ? 1'b0 : r_body_ver;

        active  = !e_failed && (e_phase != PH_ENDED);
        sig_err = (e_hdr_pos < 5'(SigLen)) && (i_byte != sig_byte(e_hdr_pos[1:0]));
        ver_n   = e_body_ver;
        if (e_hdr_pos == 5'(VerPos) && i_byte == MARK_PAUSE) begin
            ver_n = 1'b1;
        end
        if (e_hdr_pos == 5'(VerPos)) begin
            is_body = ver_n;
        end else begin
            is_body = (e_hdr_pos > 5'(VerPos)) && ((e_hdr_pos >= 5'(HdrLen)) || e_body_ver);
        end
        n_hdr_pos = (e_hdr_pos < 5'(HdrLen)) ? e_hdr_pos + 5'd1 : e_hdr_pos;

        // body decode
        skip_cnt  = {i_byte, 2'b00};
        body_v    = 1'b0;
        body_r    = '0;
        add_ticks = '0;
        phase_b   = e_phase;
        n_latch   = e_latch;
        if (active && !sig_err && is_body) begin
            case (e_phase)
                PH_IDLE: begin
                    if (i_byte == MARK_PAUSE) begin
                        add_ticks         = 10'd1;
                        body_v            = !i_count_only;
                        body_r.kind       = K_PAUSE;
                        body_r.pause_count = 10'd1;
                    end else if (i_byte == MARK_SKIP) begin
                        phase_b = PH_SKIP;
                    end else if (i_byte == MARK_END) begin
                        phase_b     = PH_ENDED;
                        body_v      = 1'b1;
                        body_r.kind = K_END;
                    end else if (i_byte < REG_LIMIT) begin
                        n_latch = i_byte[3:0];
                        phase_b = PH_REG;
                    end
                end
                PH_SKIP: begin
                    phase_b   = PH_IDLE;
                    add_ticks = skip_cnt;
                    if (skip_cnt != '0) begin
                        body_v             = !i_count_only;
                        body_r.kind        = K_PAUSE;
                        body_r.pause_count = skip_cnt;
                    end
                end
                PH_REG: begin
                    phase_b          = PH_IDLE;
                    body_v           = !i_count_only;
                    body_r.kind      = K_WRITE;
                    body_r.reg_index = e_latch;
                    body_r.reg_value = i_byte;
                end
                default: begin
                    phase_b = e_phase;
                end
            endcase
        end

        // saturating tick total
        tick_sum = {1'b0, e_ticks} + {23'd0, add_ticks};
        n_ticks  = tick_sum[32] ? '1 : tick_sum[31:0];

        // end of file: short stream is an error, otherwise end of track
        term_v  = i_last && active && !sig_err && (phase_b != PH_ENDED);
        term_r  = '0;
        term_r.kind = (n_hdr_pos < 5'(HdrLen)) ? K_ERROR : K_END;

        n_phase  = phase_b;
        n_failed = e_failed;
        if (active && sig_err) begin
            n_failed = 1'b1;
        end
        if (term_v) begin
            if (term_r.kind == K_ERROR) begin
                n_failed = 1'b1;
            end else begin
                n_phase = PH_ENDED;
            end
        end
        n_body_ver = active ? ver_n : e_body_ver;
        if (!active) begin
            n_hdr_pos = e_hdr_pos;
            n_phase   = e_phase;
            n_latch   = e_latch;
            n_ticks   = e_ticks;
        end

        err_r      = '0;
        err_r.kind = K_ERROR;

        // order the results into slots
        o_push = '0;
        if (active && sig_err) begin
            o_push.num = 2'd1;
            o_push.r0  = err_r;
        end else if (body_v && term_v) begin
            o_push.num = 2'd2;
            o_push.r0  = body_r;
            o_push.r1  = term_r;
        end else if (body_v) begin
            o_push.num = 2'd1;
            o_push.r0  = body_r;
        end else if (term_v) begin
            o_push.num = 2'd1;
            o_push.r0  = term_r;
        end
        o_push.r0.chip        = i_chip;
        o_push.r1.chip        = i_chip;
        o_push.r0.tick_total  = n_ticks;
        o_push.r1.tick_total  = n_ticks;
        o_push.r0.last_result = (o_push.num == 2'd1);
        o_push.r1.last_result = 1'b1;
        if (!i_accept) begin
            o_push.num = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos  <= '0;
            r_phase    <= PH_IDLE;
            r_latch    <= '0;
            r_ticks    <= '0;
            r_failed   <= 1'b0;
            r_body_ver <= 1'b0;
        end else if (i_accept) begin
            r_hdr_pos  <= n_hdr_pos;
            r_phase    <= n_phase;
            r_latch    <= n_latch;
            r_ticks    <= n_ticks;
            r_failed   <= n_failed;
            r_body_ver <= n_body_ver;
        end
    end

endmodule

`default_nettype wire

/* src/psp_outq.sv */
// Result queue: takes up to two results per cycle, delivers one per beat.
// Depends on psp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psp_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire psp_pkg::t_push i_push,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_pop_ready,
    output psp_pkg::t_result   o_data
);
    import psp_pkg::*;

    t_result          r_mem [QDepth];
    logic [QAw-1:0]   r_wr, n_wr;
    logic [QAw-1:0]   r_rd, n_rd;
    logic [QAw:0]     r_count, n_count;
    logic             pop;

    assign o_room  = (r_count <= (QAw+1)'(QDepth - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_wr    = r_wr + QAw'(i_push.num);
        n_rd    = pop ? r_rd + QAw'(1) : r_rd;
        n_count = r_count + (QAw+1)'(i_push.num) - (QAw+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + QAw'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // never overfill
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAw+1)'(QDepth))
        else $error("result queue count above depth");

    // pushes only land when room was flagged
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room)
        else $error("push into full result queue");

    // pointer distance tracks the count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_count[QAw-1:0])
        else $error("queue pointers disagree with count");

    // a pop advances the count by exactly the pushes minus one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_count == $past(r_count) + (QAw+1)'($past(i_push.num)) - (QAw+1)'(1))
        else $error("queue count step wrong on pop");

    // a push never carries more than two results
    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd3)
        else $error("bad push count");

endmodule

`default_nettype wire

/* src/psg_stream_parser_top.sv */
// Top level of the PSG register dump stream parser.
// Depends on psp_pkg, psp_parse and psp_outq.
//
// Usage:
//   Feed the dump file on the slave stream, one byte per beat. tuser marks
//   byte 0 of a new file (restarts the parser, keeps config), tlast marks
//   the final byte. Results leave on the master stream: tuser carries the
//   kind (write, pause, end of track, format error) and chip number, tdata
//   the register index/value, pause count and running tick total, tlast
//   flags the final result caused by one input byte.
//   Results are registered in the result queue before they leave.
//   Throughput: one byte per cycle while the queue has room; a byte that
//   causes a body result plus end/error on the last byte takes two output beats.
//   The input side stays ready while the four-entry result queue has room
//   for two results, so it keeps taking bytes while a result waits.
//   Stalls: when the receiver holds tready low, results pile up in the
//   queue and s_axis_tready drops once fewer than two entries are free.
//   Config: write count_only (index 0) or chip_number (index 1) on the cfg
//   channel while idle; the cfg channel is always ready.
//   Reset: synchronous, active low; clears parser state, queue and config.
`timescale 1ns / 1ps
`default_nettype none

module psg_stream_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data,
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] file_byte
    input  wire logic        s_axis_tuser,   // [0] first_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [3:0] register_index, [11:4] register_value,
                                             // [21:12] pause_count, [53:22] tick_total
    output logic [2:0]       m_axis_tuser,   // [1:0] kind, [2] chip
    output logic             m_axis_tlast    // last_result
);
    import psp_pkg::*;

    logic    r_count_only;
    logic    r_chip;
    logic    accept;
    logic    room;
    t_push   push;
    t_result res;

    // config registers: always ready, write on handshake
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_only <= 1'b0;
            r_chip       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COUNT_ONLY: r_count_only <= i_cfg_data;
                CFG_CHIP:       r_chip       <= i_cfg_data;
                default:        r_chip       <= r_chip;
            endcase
        end
    end

    // take a byte whenever the queue can hold its worst-case two results
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    psp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .i_first      (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_count_only (r_count_only),
        .i_chip       (r_chip),
        .o_push       (push)
    );

    psp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (res)
    );

    // pack result fields, lowest first, pad tdata to whole bytes
    assign m_axis_tdata = {2'b00, res.tick_total, res.pause_count,
                           res.reg_value, res.reg_index};
    assign m_axis_tuser = {res.chip, res.kind};
    assign m_axis_tlast = res.last_result;

endmodule

`default_nettype wire

/* test/psg_stream_parser_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of psg_stream_parser_top: streams PSG dump files byte by byte
// and checks every result beat against a parser model kept in this file.
// Depends on psp_pkg and the RTL of the parser.

module psg_stream_parser_top_tb;
    import psp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on any channel
    localparam int SETTLE_CYCLES = 8;     // idle time before a register write
    localparam int LONG_HOLD     = 300;   // one long receiver hold-off
    localparam int HOLD_AFTER    = 40;    // results seen before that hold-off
    localparam int MAX_PRINTS    = 30;

    localparam logic [7:0] SIGNATURE [4] = '{8'h50, 8'h53, 8'h47, MARK_FORMAT};

    // One input beat; where pin is set, the single result it causes is typed in.
    typedef struct packed {
        logic [7:0]  fb;
        logic        is_first;
        logic        is_last;
        logic        pin;
        logic [1:0]  kind;
        logic [9:0]  pauses;
        logic [31:0] ticks;
    } t_row;

    // Directed file set, walked once after reset with both registers at zero.
    localparam t_row SCRIPT [25] = '{
        // no first_byte flag: the first byte after reset is byte 0
        '{8'h50, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h53, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h47, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h1A, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        // version 0xFF: body starts here, and this byte is a single pause
        '{8'hFF, 1'b0, 1'b0, 1'b1, K_PAUSE, 10'd1,    32'd1},
        // skip of zero: nothing
        '{8'hFE, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        // largest skip
        '{8'hFE, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b1, K_PAUSE, 10'd1020, 32'd1021},
        // highest and lowest register, extreme values
        '{8'h0E, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        // unknown codes at both ends of their range
        '{8'h0F, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'hFC, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        // end marker, then a last byte that must stay silent
        '{8'hFD, 1'b0, 1'b0, 1'b1, K_END,   10'd0,    32'd1021},
        '{8'hFD, 1'b0, 1'b1, 1'b0, K_WRITE, 10'd0,    32'd0},
        // bad signature, rest of file ignored
        '{8'h00, 1'b1, 1'b0, 1'b1, K_ERROR, 10'd0,    32'd0},
        '{8'h50, 1'b0, 1'b1, 1'b0, K_WRITE, 10'd0,    32'd0},
        // short file with body from the version byte: pause results stand
        '{8'h50, 1'b1, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h53, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h47, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'h1A, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, K_WRITE, 10'd0,    32'd0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, K_WRITE, 10'd0,    32'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic        i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Parser model state and its copy of the registers
    bit          dump_count_only;
    bit          dump_chip;
    logic [4:0]  dump_hdr_pos;
    logic [1:0]  dump_phase;
    logic [3:0]  dump_reg_latch;
    logic [31:0] dump_ticks;
    bit          dump_failed;
    bit          dump_from_version;
    bit          byte_used;

    t_result     byte_results[$];     // results of the byte just taken
    t_result     pending_results[$];  // results still owed by the block

    bit calm;         // last part of the run: no idling on either side
    bit gaps_on;      // sender may insert gaps in the current file
    int items_used;   // bytes sent
    int results_seen;
    int mismatches;

    psg_stream_parser_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_parser();
        dump_hdr_pos      = '0;
        dump_phase        = PH_IDLE;
        dump_reg_latch    = '0;
        dump_ticks        = '0;
        dump_failed       = 1'b0;
        dump_from_version = 1'b0;
    endfunction

    function automatic void add_ticks(input logic [31:0] n);
        logic [32:0] sum;
        sum = {1'b0, dump_ticks} + {1'b0, n};
        dump_ticks = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic t_result make_result(input logic [1:0] kind, input logic [3:0] idx,
                                            input logic [7:0] val, input logic [9:0] pc);
        t_result r;
        r = '0;
        r.kind        = kind;
        r.chip        = dump_chip;
        r.reg_index   = idx;
        r.reg_value   = val;
        r.pause_count = pc;
        return r;
    endfunction

    // Advance the parser by one file byte; leave its results in byte_results.
    function automatic void parse_dump_byte(input logic [7:0] b, input logic is_first,
                                            input logic is_last);
        bit in_body;
        in_body = 1'b0;
        byte_results.delete();
        if (is_first) clear_parser();
        byte_used = !dump_failed && dump_phase != PH_ENDED;

        if (byte_used) begin
            if (dump_hdr_pos < SigLen) begin
                if (b != SIGNATURE[dump_hdr_pos[1:0]]) begin
                    dump_failed = 1'b1;
                    byte_results.push_back(make_result(K_ERROR, 4'd0, 8'd0, 10'd0));
                end
            end else if (dump_hdr_pos == VerPos) begin
                if (b == MARK_PAUSE) dump_from_version = 1'b1;
                in_body = dump_from_version;
            end else begin
                in_body = (dump_hdr_pos >= HdrLen) || dump_from_version;
            end
            if (dump_hdr_pos < HdrLen) dump_hdr_pos++;

            if (!dump_failed && in_body) begin
                case (dump_phase)
                    PH_IDLE: begin
                        if (b == MARK_PAUSE) begin
                            add_ticks(32'd1);
                            if (!dump_count_only)
                                byte_results.push_back(make_result(K_PAUSE, 4'd0, 8'd0, 10'd1));
                        end else if (b == MARK_SKIP) begin
                            dump_phase = PH_SKIP;
                        end else if (b == MARK_END) begin
                            dump_phase = PH_ENDED;
                            byte_results.push_back(make_result(K_END, 4'd0, 8'd0, 10'd0));
                        end else if (b < REG_LIMIT) begin
                            dump_reg_latch = b[3:0];
                            dump_phase     = PH_REG;
                        end
                    end
                    PH_SKIP: begin
                        dump_phase = PH_IDLE;
                        if (b != 8'd0) begin
                            add_ticks({22'd0, b, 2'b00});
                            if (!dump_count_only)
                                byte_results.push_back(make_result(K_PAUSE, 4'd0, 8'd0,
                                                                   {b, 2'b00}));
                        end
                    end
                    PH_REG: begin
                        dump_phase = PH_IDLE;
                        if (!dump_count_only)
                            byte_results.push_back(make_result(K_WRITE, dump_reg_latch, b,
                                                               10'd0));
                    end
                    default: ;
                endcase
            end

            // last byte closes the file: error if the header is short, else end
            if (is_last && !dump_failed && dump_phase != PH_ENDED) begin
                if (dump_hdr_pos < HdrLen) begin
                    dump_failed = 1'b1;
                    byte_results.push_back(make_result(K_ERROR, 4'd0, 8'd0, 10'd0));
                end else begin
                    dump_phase = PH_ENDED;
                    byte_results.push_back(make_result(K_END, 4'd0, 8'd0, 10'd0));
                end
            end
        end

        foreach (byte_results[k]) begin
            byte_results[k].tick_total  = dump_ticks;
            byte_results[k].last_result = (k == byte_results.size() - 1);
        end
    endfunction

    // ------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Take each result beat and hold it against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.kind        = m_axis_tuser[1:0];
            got.chip        = m_axis_tuser[2];
            got.reg_index   = m_axis_tdata[3:0];
            got.reg_value   = m_axis_tdata[11:4];
            got.pause_count = m_axis_tdata[21:12];
            got.tick_total  = m_axis_tdata[53:22];
            got.last_result = m_axis_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d of kind %0d with nothing owed",
                                          results_seen, got.kind));
            end else begin
                want = pending_results.pop_front();
                check_field("kind",           32'(got.kind),        32'(want.kind));
                check_field("chip",           32'(got.chip),        32'(want.chip));
                check_field("register_index", 32'(got.reg_index),   32'(want.reg_index));
                check_field("register_value", 32'(got.reg_value),   32'(want.reg_value));
                check_field("pause_count",    32'(got.pause_count), 32'(want.pause_count));
                check_field("tick_total",     got.tick_total,       want.tick_total);
                check_field("last_result",    32'(got.last_result), 32'(want.last_result));
            end
        end
    end

    // End the run when no channel moves a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stall bursts in stretches, one long hold-off so the
    // result queue fills and the input side backs up, none once calm.
    initial begin : result_sink
        int burst;
        int stretch;
        bit stalls_on;
        bit held;
        burst     = 0;
        stretch   = 0;
        stalls_on = 1'b0;
        held      = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (stretch == 0) begin
                stalls_on = ($urandom_range(0, 2) != 0);
                stretch   = $urandom_range(40, 200);
            end
            stretch--;
            if (calm) begin
                burst = 0;
                m_axis_tready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_axis_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------- stimulus

    // Offer one byte, hold it until taken, then advance the model.
    task automatic send_byte(input t_row r);
        t_result pinned;
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.fb;
        s_axis_tuser  <= r.is_first;
        s_axis_tlast  <= r.is_last;
        do @(posedge i_clk); while (!s_axis_tready);

        parse_dump_byte(r.fb, r.is_first, r.is_last);
        items_used++;
        if (r.pin) begin
            pinned             = make_result(r.kind, 4'd0, 8'd0, r.pauses);
            pinned.tick_total  = r.ticks;
            pinned.last_result = 1'b1;
            pending_results.push_back(pinned);
        end else begin
            foreach (byte_results[k]) pending_results.push_back(byte_results[k]);
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input bit count_only, input bit chip);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_COUNT_ONLY;
        i_cfg_data  <= count_only;
        do @(posedge i_clk); while (!o_cfg_ready);
        dump_count_only = count_only;
        i_cfg_index <= CFG_CHIP;
        i_cfg_data  <= chip;
        do @(posedge i_clk); while (!o_cfg_ready);
        dump_chip = chip;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Build one dump file, mostly well formed with random body, sometimes
    // broken (bad signature, cut short, no first flag, plain noise), and send it.
    task automatic send_file();
        logic [7:0] fbytes[$];
        int         shape;
        int         n_ops;
        int         keep;
        bit         by_version;
        bit         flag_first;
        t_row       r;
        shape      = $urandom_range(0, 11);
        by_version = ($urandom_range(0, 2) == 0);
        flag_first = 1'b1;
        n_ops      = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        gaps_on    = !calm && ($urandom_range(0, 3) != 0);

        foreach (SIGNATURE[k]) fbytes.push_back(SIGNATURE[k]);
        fbytes.push_back(by_version ? MARK_PAUSE : 8'($urandom_range(0, 254)));
        if (!by_version) repeat (11) fbytes.push_back(8'($urandom));

        repeat (n_ops) begin
            case ($urandom_range(0, 9))
                0, 1: fbytes.push_back(MARK_PAUSE);
                2, 3: begin
                    fbytes.push_back(MARK_SKIP);
                    if ($urandom_range(0, 5) == 0)      fbytes.push_back(8'h00);
                    else if ($urandom_range(0, 4) == 0) fbytes.push_back(8'hFF);
                    else                                fbytes.push_back(8'($urandom));
                end
                4, 5, 6, 7: begin
                    fbytes.push_back(8'($urandom_range(0, 14)));
                    fbytes.push_back(8'($urandom));
                end
                8: fbytes.push_back(8'($urandom_range(15, 252)));
                default: begin
                    if ($urandom_range(0, 3) == 0) fbytes.push_back(MARK_END);
                    else                           fbytes.push_back(8'($urandom));
                end
            endcase
        end
        // leave a skip or register write hanging on the last byte
        if ($urandom_range(0, 3) == 0)
            fbytes.push_back($urandom_range(0, 1) ? MARK_SKIP : 8'($urandom_range(0, 14)));

        case (shape)
            0: fbytes[$urandom_range(0, 3)] = 8'($urandom);
            1: begin
                keep = $urandom_range(1, 15);
                while (fbytes.size() > keep) void'(fbytes.pop_back());
            end
            2: flag_first = 1'b0;
            3: begin
                fbytes.delete();
                repeat ($urandom_range(1, 20)) fbytes.push_back(8'($urandom));
            end
            default: ;
        endcase

        foreach (fbytes[k]) begin
            r          = '0;
            r.fb       = fbytes[k];
            r.is_first = flag_first && (k == 0);
            r.is_last  = (k == fbytes.size() - 1);
            send_byte(r);
        end
    endtask

    task automatic run_files(input int target);
        int start;
        start = items_used;
        while (items_used - start < target) send_file();
        settle();
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_COUNT_ONLY;
        i_cfg_data    <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        dump_count_only = 1'b0;
        dump_chip       = 1'b0;
        clear_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gaps_on = 1'b1;
        for (int k = 0; k < $size(SCRIPT); k++) send_byte(SCRIPT[k]);
        settle();

        // walk the register settings; the last phase runs without idling
        set_config(1'b0, 1'b1);
        run_files(300);
        set_config(1'b1, 1'b1);
        run_files(150);
        set_config(1'b1, 1'b0);
        run_files(150);
        calm = 1'b1;
        set_config(1'b0, 1'b0);
        run_files(250);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
src/psp_pkg.sv
src/psp_parse.sv
src/psp_outq.sv
src/psg_stream_parser_top.sv
test/psg_stream_parser_top_tb.sv
